[hw/rtl/bce_pkg.sv]
// Shared types and constants for the byte to CJK 14-bit encoder.
`default_nettype none
package bce_pkg;

    localparam logic [15:0] UNIT_BASE   = 16'h4E00;
    localparam logic [15:0] MARK_BASE   = 16'h3D00;
    localparam int          MAX_UNITS   = 3;
    localparam logic [4:0]  UNIT_BITS   = 5'd14;
    localparam logic [4:0]  BYTE_BITS   = 5'd8;
    localparam logic [4:0]  MAX_PENDING = 5'd21;
    localparam logic [2:0]  LAST_POS    = 3'd6;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        end_of_message;
    } t_unit;

    typedef struct packed {
        t_unit [MAX_UNITS-1:0] units;
        logic  [1:0]           count;
    } t_burst;

endpackage
`default_nettype wire

[hw/rtl/bce_ifs.sv]
// Valid/ready channel interfaces for input bytes and output code units.
`default_nettype none
interface bce_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;
    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface bce_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        end_of_message;
    modport source (output valid, output code_unit, output end_of_message, input ready);
    modport sink   (input valid, input code_unit, input end_of_message, output ready);
endinterface
`default_nettype wire

[hw/rtl/bce_pack.sv]
// Bit packer: holds leftover bits and builds the units caused by one byte.
`default_nettype none
module bce_pack (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_take,
    input  wire logic [7:0]     i_data_byte,
    input  wire logic           i_final_byte,
    output bce_pkg::t_burst     o_burst
);

    logic [12:0] r_held_bits;
    logic [3:0]  r_held_count;
    logic [2:0]  r_group_pos;

    logic [20:0] acc;
    logic [4:0]  cnt;
    logic        full;
    logic [2:0]  full_sh;
    logic [13:0] full_val;
    logic [4:0]  rem;
    logic [20:0] rem_mask;
    logic [12:0] rem_bits;
    logic [26:0] pad_wide;
    logic [13:0] pad_val;
    logic [2:0]  pos;

    always_comb begin
        acc = {r_held_bits, i_data_byte};
        cnt = {1'b0, r_held_count} + bce_pkg::BYTE_BITS;
        if (cnt > bce_pkg::MAX_PENDING) begin
            cnt = bce_pkg::MAX_PENDING;
        end
        full     = (cnt >= bce_pkg::UNIT_BITS);
        full_sh  = 3'(cnt - bce_pkg::UNIT_BITS);
        full_val = 14'(acc >> full_sh);
        rem      = full ? (cnt - bce_pkg::UNIT_BITS) : cnt;
        rem_mask = 21'((22'd1 << rem) - 22'd1);
        rem_bits = 13'(acc & rem_mask);
        pad_wide = {14'd0, rem_bits} << (bce_pkg::UNIT_BITS - rem);
        pad_val  = pad_wide[13:0];
        pos      = (r_group_pos >= bce_pkg::LAST_POS) ? (r_group_pos - bce_pkg::LAST_POS)
                                                      : (r_group_pos + 3'd1);
    end

    always_comb begin
        logic [1:0] n;
        n = 2'd0;
        o_burst = '0;
        if (full) begin
            o_burst.units[n].code_unit = bce_pkg::UNIT_BASE + {2'b00, full_val};
            n = n + 2'd1;
        end
        if (i_final_byte) begin
            if (rem != 5'd0) begin
                o_burst.units[n].code_unit = bce_pkg::UNIT_BASE + {2'b00, pad_val};
                n = n + 2'd1;
            end
            if (pos != 3'd0) begin
                o_burst.units[n].code_unit = bce_pkg::MARK_BASE + {13'd0, pos};
                n = n + 2'd1;
            end
            o_burst.units[n - 2'd1].end_of_message = 1'b1;
        end
        o_burst.count = n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_bits  <= '0;
            r_held_count <= '0;
            r_group_pos  <= '0;
        end else if (i_take) begin
            if (i_final_byte) begin
                r_held_bits  <= '0;
                r_held_count <= '0;
                r_group_pos  <= '0;
            end else begin
                r_held_bits  <= rem_bits;
                r_held_count <= rem[3:0];
                r_group_pos  <= pos;
            end
        end
    end

endmodule
`default_nettype wire

[hw/rtl/bce_outq.sv]
// Result register: holds up to three units of one byte and drains one per cycle while the sink is ready.
`default_nettype none
module bce_outq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire bce_pkg::t_burst i_burst,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_valid,
    input  wire logic           i_ready,
    output bce_pkg::t_unit      o_unit
);

    bce_pkg::t_unit [bce_pkg::MAX_UNITS-1:0] r_units;
    logic [1:0]                              r_cnt;

    logic pop;
    logic load;

    assign o_valid    = (r_cnt != 2'd0);
    assign pop        = o_valid && i_ready;
    assign o_in_ready = i_rst_n && ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_ready));
    assign load       = i_in_valid && o_in_ready;
    assign o_unit     = r_units[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (load) begin
            r_cnt <= i_burst.count;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // payload, shifts toward slot 0 as words leave
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_units <= i_burst.units;
        end else if (pop) begin
            r_units <= {r_units[bce_pkg::MAX_UNITS-1], r_units[bce_pkg::MAX_UNITS-1:1]};
        end
    end

endmodule
`default_nettype wire

[hw/rtl/bytes_to_cjk_14bit_encoder.sv]
// The first code unit of a byte is valid in the cycle after the byte is accepted.
// Throughput: one byte per cycle while each byte yields at most one word and the output is ready.
// A final byte yields up to three words; the input stalls until the last one leaves
// the single output port.
// Reset (synchronous, active low) clears held bits, bit count, group position
// and the result register; ready is low during reset.
`default_nettype none
module bytes_to_cjk_14bit_encoder (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    bce_byte_if.sink     i_in,
    bce_unit_if.source   o_out
);

    bce_pkg::t_burst burst;
    bce_pkg::t_unit  unit;
    logic            in_ready;
    logic            take;

    assign take       = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    bce_pack u_pack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_data_byte  (i_in.data_byte),
        .i_final_byte (i_in.final_byte),
        .o_burst      (burst)
    );

    bce_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_burst    (burst),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_unit     (unit)
    );

    assign o_out.code_unit      = unit.code_unit;
    assign o_out.end_of_message = unit.end_of_message;

endmodule
`default_nettype wire

[hw/rtl/bce_checker.sv]
// Port-level checks for the encoder, bound to the top level.
`default_nettype none
module bce_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [15:0] i_code_unit,
    input wire logic        i_end_of_message
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_code_unit)
                                        && $stable(i_end_of_message))
        else $error("stalled word changed");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_code_unit[15:8] == 8'h3D && i_code_unit[7:3] == 5'd0
                         && i_code_unit[2:0] != 3'd0 && i_code_unit[2:0] != 3'd7)
                        || (i_code_unit >= 16'h4E00 && i_code_unit <= 16'h8DFF))
        else $error("code unit out of range");

    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_code_unit[15:8] == 8'h3D |-> i_end_of_message)
        else $error("length marker not at end of message");

endmodule

bind bytes_to_cjk_14bit_encoder bce_checker u_bce_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_code_unit      (o_out.code_unit),
    .i_end_of_message (o_out.end_of_message)
);
`default_nettype wire

[tb/sv/bytes_to_cjk_14bit_encoder_tb.sv]
// Self-checking testbench for the byte to CJK 14-bit encoder: directed and random messages.
`default_nettype none
module bytes_to_cjk_14bit_encoder_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_LIMIT = 2000;
    localparam int RANDOM_BYTES = 295;
    localparam int BURST_BYTES = 40;

    typedef logic [7:0] t_msg[$];

    logic i_clk;
    logic i_rst_n;

    bce_byte_if byte_ch ();
    bce_unit_if unit_ch ();

    bytes_to_cjk_14bit_encoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (unit_ch)
    );

    logic [12:0]     held_bits;
    logic [3:0]      held_count;
    logic [2:0]      group_pos;
    bce_pkg::t_unit  expected_units[$];
    int              mismatch_count;
    int              cycle_count;
    bit              no_idle;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int idle_cycles();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // Encoder model: queues the words one accepted byte produces.
    function automatic void encode_byte(input logic [7:0] data, input logic is_last);
        logic [20:0]    acc;
        logic [4:0]     cnt;
        logic [2:0]     pos;
        bce_pkg::t_unit words[$];
        bce_pkg::t_unit w;
        acc = {held_bits, data};
        cnt = {1'b0, held_count} + bce_pkg::BYTE_BITS;
        if (cnt > bce_pkg::MAX_PENDING) cnt = bce_pkg::MAX_PENDING;
        w.end_of_message = 1'b0;
        if (cnt >= bce_pkg::UNIT_BITS) begin
            w.code_unit = bce_pkg::UNIT_BASE
                          + 16'((acc >> (cnt - bce_pkg::UNIT_BITS)) & 21'h3FFF);
            words.push_back(w);
            cnt = cnt - bce_pkg::UNIT_BITS;
            acc = acc & ((21'd1 << cnt) - 21'd1);
        end
        pos = (group_pos == bce_pkg::LAST_POS) ? 3'd0 : group_pos + 3'd1;
        if (is_last) begin
            if (cnt != 0) begin
                w.code_unit = bce_pkg::UNIT_BASE
                              + 16'((acc << (bce_pkg::UNIT_BITS - cnt)) & 21'h3FFF);
                words.push_back(w);
            end
            if (pos != 0) begin
                w.code_unit = bce_pkg::MARK_BASE + 16'(pos);
                words.push_back(w);
            end
            words[words.size() - 1].end_of_message = 1'b1;
            held_bits  = '0;
            held_count = '0;
            group_pos  = '0;
        end else begin
            held_bits  = acc[12:0];
            held_count = cnt[3:0];
            group_pos  = pos;
        end
        foreach (words[k]) expected_units.push_back(words[k]);
    endfunction

    task automatic send_byte(input logic [7:0] data, input logic is_last);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.data_byte  <= data;
        byte_ch.final_byte <= is_last;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        encode_byte(data, is_last);
    endtask

    task automatic send_message(input t_msg msg);
        foreach (msg[k]) send_byte(msg[k], k == msg.size() - 1);
    endtask

    function automatic logic [7:0] random_byte();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic t_msg random_message(input int max_len);
        t_msg msg;
        int   len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, max_len)
                                          : $urandom_range(1, 16);
        repeat (len) msg.push_back(random_byte());
        return msg;
    endfunction

    // Single-byte messages at both extremes and a two-byte flush of three words.
    task automatic test_short_messages();
        send_message('{8'h00});
        send_message('{8'hFF});
        send_message('{8'hAA, 8'h55});
    endtask

    // Exact group of seven (four words, no padding, no marker) and a wrap into the next group.
    task automatic test_group_boundary();
        send_message('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        send_message('{8'h01, 8'h80, 8'hFE, 8'h7F, 8'hC3, 8'h3C, 8'h00, 8'hFF});
    endtask

    // Six bytes: full word, padded word and marker all on the last byte.
    task automatic test_three_word_flush();
        send_message('{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF});
    endtask

    task automatic test_random_messages();
        int   sent;
        t_msg msg;
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            msg = random_message(40);
            send_message(msg);
            sent += msg.size();
        end
    endtask

    task automatic test_back_to_back();
        int   sent;
        t_msg msg;
        sent = 0;
        no_idle = 1'b1;
        while (sent < BURST_BYTES) begin
            msg = random_message(20);
            send_message(msg);
            sent += msg.size();
        end
        no_idle = 1'b0;
    endtask

    // Sink side: runs of ready separated by random stalls.
    initial begin
        int run;
        int stall;
        forever begin
            run = $urandom_range(1, 20);
            unit_ch.ready <= 1'b1;
            repeat (run) @(posedge i_clk);
            stall = idle_cycles();
            if (stall > 0) begin
                unit_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    initial begin
        bce_pkg::t_unit want;
        forever begin
            @(posedge i_clk);
            if (unit_ch.valid && unit_ch.ready) begin
                if (expected_units.size() == 0) begin
                    $error("code_unit: unexpected word %h", unit_ch.code_unit);
                    mismatch_count++;
                end else begin
                    want = expected_units.pop_front();
                    if (unit_ch.code_unit !== want.code_unit) begin
                        $error("code_unit: expected %h, got %h",
                               want.code_unit, unit_ch.code_unit);
                        mismatch_count++;
                    end
                    if (unit_ch.end_of_message !== want.end_of_message) begin
                        $error("end_of_message: expected %b, got %b",
                               want.end_of_message, unit_ch.end_of_message);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        int drain;
        held_bits          = '0;
        held_count         = '0;
        group_pos          = '0;
        mismatch_count     = 0;
        no_idle            = 1'b0;
        i_rst_n            = 1'b0;
        byte_ch.valid      = 1'b0;
        byte_ch.data_byte  = '0;
        byte_ch.final_byte = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_short_messages();
        test_group_boundary();
        test_three_word_flush();
        test_random_messages();
        test_back_to_back();
        byte_ch.valid <= 1'b0;

        drain = 0;
        while (expected_units.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (10) @(posedge i_clk);
        if (expected_units.size() != 0) begin
            $error("code_unit: %0d expected words never arrived", expected_units.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
`default_nettype wire

[sim.f]
hw/rtl/bce_pkg.sv
hw/rtl/bce_ifs.sv
hw/rtl/bce_pack.sv
hw/rtl/bce_outq.sv
hw/rtl/bytes_to_cjk_14bit_encoder.sv
hw/rtl/bce_checker.sv
tb/sv/bytes_to_cjk_14bit_encoder_tb.sv
